// ----- hw/rtl/slsd_pkg.sv -----
// ----------------------------------------------------------------------------
// slsd_pkg: shared types, constants and generator step functions
// Command codes, generator constants, the queue entry layout and the two
// modular step functions of the keystream generators.
// ----------------------------------------------------------------------------
package slsd_pkg;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_SEED    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_DECRYPT = 2'd2;

    // Generator seeds used after reset and in place of a zero seed half.
    localparam logic [15:0] LOW_DEFAULT  = 16'h7F8D;
    localparam logic [15:0] HIGH_DEFAULT = 16'h2345;

    // Multipliers and moduli of the two Lehmer generators.
    localparam logic [15:0] LOW_MULT  = 16'h7F8D;
    localparam logic [15:0] HIGH_MULT = 16'h2345;
    localparam logic [16:0] LOW_MOD   = 17'h0FFF1;
    localparam logic [16:0] HIGH_MOD  = 17'h0FFD9;

    // 2^16 reduced by each modulus, used to fold the upper product bits.
    localparam logic [16:0] LOW_FOLD  = 17'h10000 - LOW_MOD;
    localparam logic [16:0] HIGH_FOLD = 17'h10000 - HIGH_MOD;

    // Substitution table geometry, fixed by the byte fields.
    localparam int TABLE_WIDTH = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int WORD_BYTES  = 4;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One queued operation: a table load or a decrypt with its keystream.
    // For a load, data holds the index in bits 15..8 and the byte in 7..0.
    typedef struct packed {
        logic        is_load;
        logic [31:0] data;
        logic [31:0] keystream;
    } slsd_entry_t;

    // low * 0x7F8D mod 0xFFF1, by folding the upper product bits twice.
    function automatic logic [15:0] gen_low_step(input logic [15:0] x);
        logic [30:0] prod;
        logic [19:0] fold1;
        logic [16:0] fold2;
        prod  = 31'(x) * 31'(LOW_MULT);
        fold1 = 20'(prod[30:16]) * 20'(LOW_FOLD) + 20'(prod[15:0]);
        fold2 = 17'(fold1[19:16]) * LOW_FOLD + 17'(fold1[15:0]);
        if (fold2 >= LOW_MOD)
        begin
            fold2 = fold2 - LOW_MOD;
        end
        return fold2[15:0];
    endfunction

    // high * 0x2345 mod 0xFFD9, same folding scheme.
    function automatic logic [15:0] gen_high_step(input logic [15:0] x);
        logic [29:0] prod;
        logic [19:0] fold1;
        logic [16:0] fold2;
        prod  = 30'(x) * 30'(HIGH_MULT);
        fold1 = 20'(prod[29:16]) * 20'(HIGH_FOLD) + 20'(prod[15:0]);
        fold2 = 17'(fold1[19:16]) * HIGH_FOLD + 17'(fold1[15:0]);
        if (fold2 >= HIGH_MOD)
        begin
            fold2 = fold2 - HIGH_MOD;
        end
        return fold2[15:0];
    endfunction

endpackage

// ----- hw/rtl/sbox_lcg_stream_decrypt_unit.sv -----
// ----------------------------------------------------------------------------
// sbox_lcg_stream_decrypt_unit: substitution and keystream word decryptor
// Takes one command beat per clock while item_stall is low: set seed, load
// one byte of the 256-entry substitution table, or decrypt one 32-bit word.
// Only a decrypt produces a result beat; results leave in command order via
// the operation queue, lookup stage and output register, at a rate of one word
// per cycle while result_stall is low. The rate is set by the generator
// update in the front, which finishes one modular step of each generator per
// cycle, and by the four table copies in the back, which serve all four bytes
// of a word in a single read. item_stall rises only when the operation queue
// (QUEUE_DEPTH entries) is full. The table is not cleared at reset: decrypting
// a byte whose table entry was never loaded gives an undefined byte.
// ----------------------------------------------------------------------------
module sbox_lcg_stream_decrypt_unit #(
    parameter int QUEUE_DEPTH = slsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic [31:0] seed_value,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    input  logic [31:0] cipher_word,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] plain_word
);
    import slsd_pkg::*;

    logic        push;
    slsd_entry_t push_entry;
    logic        pop;
    slsd_entry_t head;
    logic        not_empty;
    logic        queue_full;

    // Front: intake, seeding and keystream generation.
    slsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .queue_full  (queue_full),
        .command     (command),
        .seed_value  (seed_value),
        .table_index (table_index),
        .table_value (table_value),
        .cipher_word (cipher_word),
        .item_stall  (item_stall),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Queue between the two halves.
    slsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .full       (queue_full)
    );

    // Back: table access and result delivery.
    slsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .not_empty    (not_empty),
        .result_stall (result_stall),
        .pop          (pop),
        .result_valid (result_valid),
        .plain_word   (plain_word)
    );

endmodule

// ----- hw/rtl/slsd_ram.sv -----
// ----------------------------------------------------------------------------
// slsd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/slsd_front.sv -----
// ----------------------------------------------------------------------------
// slsd_front: command intake and keystream generators
// Accepts input beats, applies seeds, steps the generators for each decrypt
// and hands loads and decrypts to the queue.
// ----------------------------------------------------------------------------
module slsd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 queue_full,
    input  logic [1:0]           command,
    input  logic [31:0]          seed_value,
    input  logic [7:0]           table_index,
    input  logic [7:0]           table_value,
    input  logic [31:0]          cipher_word,
    output logic                 item_stall,
    output logic                 push,
    output slsd_pkg::slsd_entry_t push_entry
);
    import slsd_pkg::*;

    logic        accept;
    logic [15:0] gen_low_reg;
    logic [15:0] gen_low_next;
    logic [15:0] gen_high_reg;
    logic [15:0] gen_high_next;
    logic [15:0] low_step;
    logic [15:0] high_step;

    // The queue alone decides whether a beat can be taken.
    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    // One step of each generator from the current state.
    assign low_step  = gen_low_step(gen_low_reg);
    assign high_step = gen_high_step(gen_high_reg);

    // Classify the beat: seed, load, decrypt, or an unused code.
    always_comb
    begin
        gen_low_next  = gen_low_reg;
        gen_high_next = gen_high_reg;
        push          = 1'b0;
        push_entry.is_load   = 1'b0;
        push_entry.data      = cipher_word;
        push_entry.keystream = {high_step, low_step};
        if (accept)
        begin
            unique case (command)
                CMD_SEED:
                begin
                    gen_low_next  = (seed_value[15:0] == 16'h0000) ? LOW_DEFAULT
                                                                   : seed_value[15:0];
                    gen_high_next = (seed_value[31:16] == 16'h0000) ? HIGH_DEFAULT
                                                                    : seed_value[31:16];
                end
                CMD_LOAD:
                begin
                    push               = 1'b1;
                    push_entry.is_load = 1'b1;
                    push_entry.data    = {16'h0000, table_index, table_value};
                end
                CMD_DECRYPT:
                begin
                    push          = 1'b1;
                    gen_low_next  = low_step;
                    gen_high_next = high_step;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_low_reg  <= LOW_DEFAULT;
            gen_high_reg <= HIGH_DEFAULT;
        end
        else
        begin
            gen_low_reg  <= gen_low_next;
            gen_high_reg <= gen_high_next;
        end
    end

endmodule

// ----- hw/rtl/slsd_queue.sv -----
// ----------------------------------------------------------------------------
// slsd_queue: operation queue between front and back
// A small circular buffer of loads and decrypts that lets the front and the
// back stall independently.
// ----------------------------------------------------------------------------
module slsd_queue #(
    parameter int DEPTH = slsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  slsd_pkg::slsd_entry_t push_entry,
    input  logic                  pop,
    output slsd_pkg::slsd_entry_t head,
    output logic                  not_empty,
    output logic                  full
);
    import slsd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    slsd_entry_t   slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign head      = slots_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    // A push into a full queue would overwrite a pending operation.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");

    // A pop from an empty queue would replay a stale operation.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue pop while empty");

    // Occupancy grows by one on a lone push.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    // Occupancy shrinks by one on a lone pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not follow a pop");
`endif

endmodule

// ----- hw/rtl/slsd_back.sv -----
// ----------------------------------------------------------------------------
// slsd_back: substitution table and result stage
// Executes queued loads and decrypts in order: loads write the table, decrypts
// read four table bytes, mix in the keystream and fill the output register.
// ----------------------------------------------------------------------------
module slsd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slsd_pkg::slsd_entry_t head,
    input  logic                  not_empty,
    input  logic                  result_stall,
    output logic                  pop,
    output logic                  result_valid,
    output logic [31:0]           plain_word
);
    import slsd_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                   table_wr;
    logic                   table_rd;
    logic [31:0]            sub_word;
    logic                   lookup_valid_reg;
    logic [31:0]            lookup_key_reg;
    logic                   lookup_move;
    logic                   lookup_free;
    logic                   result_valid_reg;
    logic [31:0]            plain_word_reg;

    // The lookup stage advances when the output register is free or drains.
    assign lookup_move = lookup_valid_reg && (!result_valid_reg || !result_stall);
    assign lookup_free = !lookup_valid_reg || lookup_move;

    // A load needs only the table; a decrypt needs room in the lookup stage.
    assign pop      = not_empty && (head.is_load || lookup_free);
    assign table_wr = pop && head.is_load;
    assign table_rd = pop && !head.is_load;

    // One table copy per byte lane so that all four bytes read at once.
    for (genvar lane = 0; lane < WORD_BYTES; lane++)
    begin : g_lane
        slsd_ram #(
            .WIDTH (TABLE_WIDTH),
            .DEPTH (TABLE_DEPTH)
        ) u_table (
            .clk     (clk),
            .wr_en   (table_wr),
            .wr_addr (head.data[15:8]),
            .wr_data (head.data[7:0]),
            .rd_en   (table_rd),
            .rd_addr (head.data[lane*TABLE_WIDTH +: AW]),
            .rd_data (sub_word[lane*TABLE_WIDTH +: TABLE_WIDTH])
        );
    end

    // Lookup stage: keystream travels beside the table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_valid_reg <= 1'b0;
        end
        else if (table_rd)
        begin
            lookup_valid_reg <= 1'b1;
        end
        else if (lookup_move)
        begin
            lookup_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (table_rd)
        begin
            lookup_key_reg <= head.keystream;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (lookup_move)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_move)
        begin
            plain_word_reg <= sub_word ^ lookup_key_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign plain_word   = plain_word_reg;

endmodule

// ----- bench/sbox_lcg_stream_decrypt_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_lcg_stream_decrypt_unit_tb: self-checking bench for the word decryptor
// Drives seed, table-load, decrypt and unused-command beats with random idling
// on both channels. A local predictor keeps its own copy of the substitution
// table and the two generators, and every plain word that leaves the block is
// compared against the oldest predicted word.
// ----------------------------------------------------------------------------
module sbox_lcg_stream_decrypt_unit_tb;

    import slsd_pkg::*;

    // The one command code the block leaves unused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  command;
    logic [31:0] seed_value;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [31:0] cipher_word;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] plain_word;

    // Predictor state: table image and both generator values.
    logic [7:0]  sbox_image [TABLE_DEPTH];
    logic [15:0] keystream_low;
    logic [15:0] keystream_high;
    logic [31:0] pending_plain [$];

    bit          idle_on;
    int unsigned stall_left = 0;
    int unsigned fail_count;
    int unsigned words_checked;
    int unsigned loads_sent;
    int unsigned seeds_sent;
    int unsigned unused_sent;

    sbox_lcg_stream_decrypt_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .seed_value   (seed_value),
        .table_index  (table_index),
        .table_value  (table_value),
        .cipher_word  (cipher_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .plain_word   (plain_word)
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Update the predictor with one accepted beat.
    task automatic apply_command(input logic [1:0] cmd, input logic [31:0] seed,
                                 input logic [7:0] idx, input logic [7:0] val,
                                 input logic [31:0] word);
        logic [31:0] subst;
        logic [31:0] next_low;
        logic [31:0] next_high;
        case (cmd)
            CMD_SEED:
            begin
                keystream_low  = (seed[15:0] == 16'h0) ? LOW_DEFAULT : seed[15:0];
                keystream_high = (seed[31:16] == 16'h0) ? HIGH_DEFAULT : seed[31:16];
                seeds_sent++;
            end
            CMD_LOAD:
            begin
                sbox_image[idx] = val;
                loads_sent++;
            end
            CMD_DECRYPT:
            begin
                for (int b = 0; b < WORD_BYTES; b++)
                begin
                    subst[8*b +: 8] = sbox_image[word[8*b +: 8]];
                end
                next_low  = (32'(keystream_low) * 32'(LOW_MULT)) % 32'(LOW_MOD);
                next_high = (32'(keystream_high) * 32'(HIGH_MULT)) % 32'(HIGH_MOD);
                keystream_low  = next_low[15:0];
                keystream_high = next_high[15:0];
                pending_plain.push_back(subst ^ {keystream_high, keystream_low});
            end
            default:
            begin
                unused_sent++;
            end
        endcase
    endtask

    // Send one beat, with an optional idle gap ahead of it. Entered and left
    // at a falling edge.
    task automatic send_beat(input logic [1:0] cmd, input logic [31:0] seed,
                             input logic [7:0] idx, input logic [7:0] val,
                             input logic [31:0] word);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        seed_value  <= seed;
        table_index <= idx;
        table_value <= val;
        cipher_word <= word;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        apply_command(cmd, seed, idx, val, word);
        @(negedge clk);
    endtask

    // Pick a seed half that often lands on zero, the modulus or above it.
    function automatic logic [15:0] pick_seed_half(input logic [15:0] modulus);
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return modulus;
            2: return 16'hFFFF;
            3: return modulus + 16'($urandom_range(1, 32'hFFFF - 32'(modulus)));
            default: return 16'($urandom);
        endcase
    endfunction

    // One random beat, mostly decrypts, with all fields random.
    task automatic send_random_beat();
        logic [1:0] cmd;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            cmd = CMD_DECRYPT;
        end
        else if (pick < 88)
        begin
            cmd = CMD_LOAD;
        end
        else if (pick < 96)
        begin
            cmd = CMD_SEED;
        end
        else
        begin
            cmd = CMD_UNUSED;
        end
        send_beat(cmd, {pick_seed_half(HIGH_MOD[15:0]), pick_seed_half(LOW_MOD[15:0])},
                  8'($urandom), 8'($urandom), $urandom);
    endtask

    // Random receiver stall bursts while idling is on.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 6);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Compare each result beat with the oldest predicted word.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_plain.size() == 0)
            begin
                $error("plain_word: result beat with no word expected, actual %h",
                       plain_word);
                fail_count++;
            end
            else
            begin
                if (plain_word !== pending_plain[0])
                begin
                    $error("plain_word mismatch: expected %h, actual %h",
                           pending_plain[0], plain_word);
                    fail_count++;
                end
                void'(pending_plain.pop_front());
                words_checked++;
            end
        end
    end

    // Edges of every field, default and replaced seeds, generators stuck at
    // zero, an unused command and a table overwrite. Only the four table
    // entries loaded here are read.
    task automatic test_directed();
        send_beat(CMD_LOAD, $urandom, 8'h00, 8'hA5, $urandom);
        send_beat(CMD_LOAD, $urandom, 8'hFF, 8'h3C, $urandom);
        send_beat(CMD_LOAD, $urandom, 8'h80, 8'h01, $urandom);
        send_beat(CMD_LOAD, $urandom, 8'h7F, 8'hFE, $urandom);
        // Generators still at their reset values.
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h0000_0000);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'hFFFF_FFFF);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h807F_00FF);
        // Both halves zero, so both are replaced.
        send_beat(CMD_SEED, 32'h0000_0000, 8'($urandom), 8'($urandom), $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'hFF00_7F80);
        send_beat(CMD_SEED, 32'hFFFF_FFFF, 8'($urandom), 8'($urandom), $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h00FF_807F);
        // Halves equal to the moduli drive both generators to zero for good.
        send_beat(CMD_SEED, {HIGH_MOD[15:0], LOW_MOD[15:0]},
                  8'($urandom), 8'($urandom), $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h7F80_FF00);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'hFFFF_0000);
        send_beat(CMD_SEED, 32'h0001_0001, 8'($urandom), 8'($urandom), $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h0000_FFFF);
        // Unused command leaves state alone.
        send_beat(CMD_UNUSED, $urandom, 8'($urandom), 8'($urandom), $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h8080_7F7F);
        // Only one half zero.
        send_beat(CMD_SEED, 32'h0000_FFF0, 8'($urandom), 8'($urandom), $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'hFF7F_8000);
        send_beat(CMD_SEED, 32'hFFDA_0000, 8'($urandom), 8'($urandom), $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h0080_FF7F);
        // Overwrite an entry and read it back.
        send_beat(CMD_LOAD, $urandom, 8'h00, 8'h00, $urandom);
        send_beat(CMD_DECRYPT, $urandom, 8'($urandom), 8'($urandom), 32'h0000_0000);
    endtask

    // Load every table entry once, in shuffled order, so that any byte may
    // be decrypted from here on.
    task automatic test_table_fill();
        logic [7:0] order [TABLE_DEPTH];
        logic [7:0] swap;
        int unsigned j;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            order[i] = 8'(i);
        end
        for (int i = TABLE_DEPTH - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            send_beat(CMD_LOAD, $urandom, order[i], 8'($urandom), $urandom);
        end
    endtask

    // Random traffic with idling on both channels.
    task automatic test_random_traffic();
        repeat (780)
        begin
            send_random_beat();
        end
    endtask

    // Final stretch at full rate with no idling at all.
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (200)
        begin
            send_random_beat();
        end
    endtask

    // Drain the remaining words, then let the pipeline settle.
    task automatic drain_results();
        int unsigned waited;
        item_valid <= 1'b0;
        waited = 0;
        while (pending_plain.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_plain.size() != 0)
        begin
            $error("plain_word: %0d expected words never arrived", pending_plain.size());
            fail_count++;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        command        = CMD_SEED;
        seed_value     = '0;
        table_index    = '0;
        table_value    = '0;
        cipher_word    = '0;
        idle_on        = 1'b1;
        fail_count     = 0;
        words_checked  = 0;
        loads_sent     = 0;
        seeds_sent     = 0;
        unused_sent    = 0;
        keystream_low  = LOW_DEFAULT;
        keystream_high = HIGH_DEFAULT;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sbox_image[i] = 8'h00;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_table_fill();
        test_random_traffic();
        test_full_rate();
        drain_results();

        $display("Checked %0d decrypted words across %0d table loads and %0d seed beats,",
                 words_checked, loads_sent, seeds_sent);
        $display("with %0d unused commands and random idling on both channels.",
                 unused_sent);
        if (fail_count == 0)
        begin
            $display("sbox_lcg_stream_decrypt_unit_tb: PASS");
        end
        else
        begin
            $display("sbox_lcg_stream_decrypt_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("sbox_lcg_stream_decrypt_unit_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/slsd_pkg.sv
hw/rtl/slsd_ram.sv
hw/rtl/slsd_front.sv
hw/rtl/slsd_queue.sv
hw/rtl/slsd_back.sv
hw/rtl/sbox_lcg_stream_decrypt_unit.sv
bench/sbox_lcg_stream_decrypt_unit_tb.sv
